// File: rtl/ers_pkg.sv
package ers_pkg;

   // Default depth of the send timestamp store
   localparam int unsigned ERS_STAMP_DEPTH = 1024;

   // Field widths
   localparam int ERS_KIND_W  = 1;
   localparam int ERS_TIME_W  = 48;
   localparam int ERS_SEQ_W   = 16;
   localparam int ERS_TYPE_W  = 8;
   localparam int ERS_IDENT_W = 16;
   localparam int ERS_HDR_W   = 4;
   localparam int ERS_LEN_W   = 16;
   localparam int ERS_RTT_W   = 32;
   localparam int ERS_SUM_W   = 48;
   localparam int ERS_SQ_W    = 64;
   localparam int ERS_CNT_W   = 32;

   // Event kinds
   localparam logic [ERS_KIND_W-1:0] ERS_KIND_SEND  = 1'b0;
   localparam logic [ERS_KIND_W-1:0] ERS_KIND_REPLY = 1'b1;

   // ICMP type of an echo reply
   localparam logic [ERS_TYPE_W-1:0] ERS_ECHO_REPLY = 8'd0;

   // Minimum RTT before any reply has been seen
   localparam logic [ERS_RTT_W-1:0] ERS_MIN_RESET = 32'd9999000;

endpackage

// File: rtl/ers_req_if.sv
interface ers_req_if import ers_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [ERS_KIND_W-1:0]   req_type;
   logic [ERS_TIME_W-1:0]   time_us;
   logic [ERS_SEQ_W-1:0]    seq_num;
   logic [ERS_TYPE_W-1:0]   msg_type;
   logic [ERS_IDENT_W-1:0]  msg_ident;
   logic [ERS_HDR_W-1:0]    header_words;
   logic [ERS_LEN_W-1:0]    packet_bytes;

   modport source (
      output valid, req_type, time_us, seq_num, msg_type, msg_ident, header_words,
             packet_bytes,
      input  ready
   );

   modport sink (
      input  valid, req_type, time_us, seq_num, msg_type, msg_ident, header_words,
             packet_bytes,
      output ready
   );
endinterface

// File: rtl/ers_rsp_if.sv
interface ers_rsp_if import ers_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [ERS_SEQ_W-1:0]    seq_assigned;
   logic                    reply_accepted;
   logic [ERS_RTT_W-1:0]    rtt_us;
   logic [ERS_LEN_W-1:0]    payload_bytes;
   logic [ERS_RTT_W-1:0]    rtt_min_us;
   logic [ERS_RTT_W-1:0]    rtt_max_us;
   logic [ERS_SUM_W-1:0]    rtt_sum_us;
   logic [ERS_SQ_W-1:0]     rtt_sq_sum;
   logic [ERS_CNT_W-1:0]    sent_total;
   logic [ERS_CNT_W-1:0]    received_total;

   modport source (
      output valid, seq_assigned, reply_accepted, rtt_us, payload_bytes, rtt_min_us,
             rtt_max_us, rtt_sum_us, rtt_sq_sum, sent_total, received_total,
      input  ready
   );

   modport sink (
      input  valid, seq_assigned, reply_accepted, rtt_us, payload_bytes, rtt_min_us,
             rtt_max_us, rtt_sum_us, rtt_sq_sum, sent_total, received_total,
      output ready
   );
endinterface

// File: rtl/echo_rtt_statistics.sv
// Echo round-trip-time statistics. Every word on req_chan (a send or a reply event) gives
// exactly one word on rsp_chan, in order. The block takes one word per clock while rsp_chan
// is ready, and the result passes through seven registers: an input register, two
// stages that reduce the reply's sequence number modulo STAMP_DEPTH by a reciprocal
// multiply, the timestamp store access, the 48-bit RTT subtract, the 32x32 square with the
// min/max/sum update, and the sum-of-squares update into the output register. Each stage
// moves on as soon as the one after it has room, so bubbles close up under back-pressure.
// The timestamp store needs no clearing pass after reset: the send counter doubles as its
// fill count, and an entry at or above it reads as zero. The user writes echo_ident through
// csr_wr_en and csr_wr_data only while the block is idle; the block does not enforce this.
module echo_rtt_statistics import ers_pkg::*; #(
   parameter int unsigned STAMP_DEPTH = ERS_STAMP_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   ers_req_if.sink                 req_chan,
   ers_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [ERS_IDENT_W-1:0]  csr_wr_data
);

   // Store index width and reciprocal constants for seq mod STAMP_DEPTH
   localparam int IDX_W       = $clog2(STAMP_DEPTH);
   localparam int MULT_W      = ERS_SEQ_W + 1;
   localparam int PROD_W      = ERS_SEQ_W + MULT_W;
   localparam int MOD_W       = ERS_SEQ_W + 1;
   localparam int RECIP_SHIFT = ERS_SEQ_W + IDX_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(STAMP_DEPTH) - 64'd1) / 64'(STAMP_DEPTH);
   localparam logic [MULT_W-1:0] RECIP_MULT = RECIP_FULL[MULT_W-1:0];
   localparam logic [MOD_W-1:0]  DEPTH_MOD  = MOD_W'(STAMP_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(STAMP_DEPTH - 1);
   localparam int NSTAGE = 7;

   typedef struct packed {
      logic [ERS_KIND_W-1:0]  kind;
      logic                   acc;
      logic [ERS_TIME_W-1:0]  time_us;
      logic [ERS_SEQ_W-1:0]   seq_num;
      logic [ERS_LEN_W-1:0]   pay;
   } item_type;

   typedef struct packed {
      logic                   acc;
      logic [ERS_SEQ_W-1:0]   seq_out;
      logic [ERS_LEN_W-1:0]   pay;
      logic [ERS_CNT_W-1:0]   sent;
   } tag_type;

   // Stage control
   logic [NSTAGE:1] vld_ff, vld_in;
   logic [NSTAGE:1] stage_free, stage_load;

   // Configuration
   logic [ERS_IDENT_W-1:0] ident_ff;

   // Stage 1: input register
   item_type it1_ff, it1_in;
   logic [ERS_HDR_W+1:0] hdr_bytes;

   // Stage 2: quotient
   item_type it2_ff;
   logic [ERS_SEQ_W-1:0] quot2_ff, quot2_in;
   logic [PROD_W-1:0]    quot_prod;

   // Stage 3: store index
   item_type it3_ff;
   logic [IDX_W-1:0]  idx3_ff, idx3_in;
   logic [MOD_W-1:0]  idx_wide;

   // Stage 4: store access and send counter
   logic [ERS_TIME_W-1:0] stamp_mem [STAMP_DEPTH];
   item_type              it4_ff;
   logic [ERS_TIME_W-1:0] stamp4_ff;
   logic                  hit4_ff;
   logic [ERS_SEQ_W-1:0]  seq4_ff;
   logic [ERS_CNT_W-1:0]  sent4_ff;
   logic [ERS_CNT_W-1:0]  sent_ff, sent_in;
   logic [IDX_W-1:0]      wr_ptr_ff, wr_ptr_in;

   // Stage 5: RTT
   tag_type               tag5_ff;
   logic [ERS_RTT_W-1:0]  rtt5_ff, rtt5_in;
   logic [ERS_TIME_W-1:0] rtt_diff;

   // Stage 6: square, count, min, max, sum
   tag_type               tag6_ff;
   logic [ERS_RTT_W-1:0]  rtt6_ff;
   logic [ERS_SQ_W-1:0]   sq6_ff, sq6_in;
   logic [ERS_CNT_W-1:0]  recv_ff, recv_in;
   logic [ERS_RTT_W-1:0]  min_ff, min_in;
   logic [ERS_RTT_W-1:0]  max_ff, max_in;
   logic [ERS_SUM_W-1:0]  sum_ff, sum_in;
   logic [ERS_SUM_W:0]    sum_wide;
   logic [ERS_CNT_W-1:0]  recv6_ff;
   logic [ERS_RTT_W-1:0]  min6_ff, max6_ff;
   logic [ERS_SUM_W-1:0]  sum6_ff;

   // Stage 7: sum of squares and output register
   logic [ERS_SQ_W-1:0]   sq_sum_ff, sq_sum_in;
   logic [ERS_SQ_W:0]     sq_wide;
   tag_type               tag7_ff;
   logic [ERS_RTT_W-1:0]  rtt7_ff, min7_ff, max7_ff;
   logic [ERS_SUM_W-1:0]  sum7_ff;
   logic [ERS_SQ_W-1:0]   sq7_ff;
   logic [ERS_CNT_W-1:0]  recv7_ff;

   // Handshake: a stage takes a word when it is empty or its own word moves on
   always_comb begin
      stage_free[NSTAGE] = !vld_ff[NSTAGE] || rsp_chan.ready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         stage_free[k] = !vld_ff[k] || stage_free[k+1];
      end
      stage_load[1] = req_chan.valid && stage_free[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         stage_load[k] = vld_ff[k-1] && stage_free[k];
      end
      vld_in = vld_ff;
      for (int k = 1; k <= NSTAGE; k++) begin
         if (stage_free[k]) begin
            vld_in[k] = stage_load[k];
         end
      end
   end

   assign req_chan.ready = stage_free[1];

   // Stage 1: reply filter and payload length
   always_comb begin
      hdr_bytes      = {req_chan.header_words, 2'b00};
      it1_in.kind    = req_chan.req_type;
      it1_in.acc     = (req_chan.req_type == ERS_KIND_REPLY)
                       && (req_chan.msg_type == ERS_ECHO_REPLY)
                       && (req_chan.msg_ident == ident_ff);
      it1_in.time_us = req_chan.time_us;
      it1_in.seq_num = req_chan.seq_num;
      if (it1_in.acc && (req_chan.packet_bytes >= ERS_LEN_W'(hdr_bytes))) begin
         it1_in.pay = req_chan.packet_bytes - ERS_LEN_W'(hdr_bytes);
      end else begin
         it1_in.pay = '0;
      end
   end

   // Stage 2: quotient of seq by depth through the reciprocal
   always_comb begin
      quot_prod = PROD_W'(it1_ff.seq_num) * PROD_W'(RECIP_MULT);
      quot2_in  = ERS_SEQ_W'(quot_prod >> RECIP_SHIFT);
   end

   // Stage 3: remainder is the store index
   always_comb begin
      idx_wide = MOD_W'(it2_ff.seq_num) - MOD_W'(quot2_ff) * DEPTH_MOD;
      idx3_in  = idx_wide[IDX_W-1:0];
   end

   // Stage 4: send counter and write pointer, both stick once the counter is full
   always_comb begin
      sent_in   = sent_ff;
      wr_ptr_in = wr_ptr_ff;
      if (stage_load[4] && (it3_ff.kind == ERS_KIND_SEND) && (sent_ff != '1)) begin
         sent_in   = sent_ff + 1'b1;
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
   end

   // Stage 5: modular difference, saturated to 32 bits
   always_comb begin
      rtt_diff = it4_ff.time_us - (hit4_ff ? stamp4_ff : '0);
      if (!it4_ff.acc) begin
         rtt5_in = '0;
      end else if (|rtt_diff[ERS_TIME_W-1:ERS_RTT_W]) begin
         rtt5_in = '1;
      end else begin
         rtt5_in = rtt_diff[ERS_RTT_W-1:0];
      end
   end

   // Stage 6: square and running statistics
   always_comb begin
      sq6_in   = ERS_SQ_W'(rtt5_ff) * ERS_SQ_W'(rtt5_ff);
      sum_wide = (ERS_SUM_W+1)'(sum_ff) + (ERS_SUM_W+1)'(rtt5_ff);
      recv_in  = recv_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      if (stage_load[6] && tag5_ff.acc) begin
         if (recv_ff != '1) begin
            recv_in = recv_ff + 1'b1;
         end
         if (rtt5_ff < min_ff) begin
            min_in = rtt5_ff;
         end
         if (rtt5_ff > max_ff) begin
            max_in = rtt5_ff;
         end
         sum_in = sum_wide[ERS_SUM_W] ? '1 : sum_wide[ERS_SUM_W-1:0];
      end
   end

   // Stage 7: saturating sum of squares
   always_comb begin
      sq_wide   = (ERS_SQ_W+1)'(sq_sum_ff) + (ERS_SQ_W+1)'(sq6_ff);
      sq_sum_in = sq_sum_ff;
      if (stage_load[7] && tag6_ff.acc) begin
         sq_sum_in = sq_wide[ERS_SQ_W] ? '1 : sq_wide[ERS_SQ_W-1:0];
      end
   end

   // Control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         ident_ff  <= '0;
         sent_ff   <= '0;
         wr_ptr_ff <= '0;
         recv_ff   <= '0;
         min_ff    <= ERS_MIN_RESET;
         max_ff    <= '0;
         sum_ff    <= '0;
         sq_sum_ff <= '0;
      end else begin
         vld_ff    <= vld_in;
         if (csr_wr_en) begin
            ident_ff <= csr_wr_data;
         end
         sent_ff   <= sent_in;
         wr_ptr_ff <= wr_ptr_in;
         recv_ff   <= recv_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         sum_ff    <= sum_in;
         sq_sum_ff <= sq_sum_in;
      end
   end

   // Timestamp store: sends write at the write pointer, replies read at the index
   always_ff @(posedge clock) begin
      if (stage_load[4] && (it3_ff.kind == ERS_KIND_SEND)) begin
         stamp_mem[wr_ptr_ff] <= it3_ff.time_us;
      end
      if (stage_load[4]) begin
         stamp4_ff <= stamp_mem[idx3_ff];
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         it1_ff <= it1_in;
      end
      if (stage_load[2]) begin
         it2_ff   <= it1_ff;
         quot2_ff <= quot2_in;
      end
      if (stage_load[3]) begin
         it3_ff  <= it2_ff;
         idx3_ff <= idx3_in;
      end
      if (stage_load[4]) begin
         it4_ff   <= it3_ff;
         hit4_ff  <= sent_ff > ERS_CNT_W'(idx3_ff);
         seq4_ff  <= (it3_ff.kind == ERS_KIND_SEND) ? sent_ff[ERS_SEQ_W-1:0] : '0;
         sent4_ff <= sent_in;
      end
      if (stage_load[5]) begin
         tag5_ff.acc     <= it4_ff.acc;
         tag5_ff.seq_out <= seq4_ff;
         tag5_ff.pay     <= it4_ff.pay;
         tag5_ff.sent    <= sent4_ff;
         rtt5_ff         <= rtt5_in;
      end
      if (stage_load[6]) begin
         tag6_ff  <= tag5_ff;
         rtt6_ff  <= rtt5_ff;
         sq6_ff   <= sq6_in;
         recv6_ff <= recv_in;
         min6_ff  <= min_in;
         max6_ff  <= max_in;
         sum6_ff  <= sum_in;
      end
      if (stage_load[7]) begin
         tag7_ff  <= tag6_ff;
         rtt7_ff  <= rtt6_ff;
         recv7_ff <= recv6_ff;
         min7_ff  <= min6_ff;
         max7_ff  <= max6_ff;
         sum7_ff  <= sum6_ff;
         sq7_ff   <= sq_sum_in;
      end
   end

   // Result word
   assign rsp_chan.valid          = vld_ff[NSTAGE];
   assign rsp_chan.seq_assigned   = tag7_ff.seq_out;
   assign rsp_chan.reply_accepted = tag7_ff.acc;
   assign rsp_chan.rtt_us         = rtt7_ff;
   assign rsp_chan.payload_bytes  = tag7_ff.pay;
   assign rsp_chan.rtt_min_us     = min7_ff;
   assign rsp_chan.rtt_max_us     = max7_ff;
   assign rsp_chan.rtt_sum_us     = sum7_ff;
   assign rsp_chan.rtt_sq_sum     = sq7_ff;
   assign rsp_chan.sent_total     = tag7_ff.sent;
   assign rsp_chan.received_total = recv7_ff;

   // The reciprocal reduction must land inside the store
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (ERS_CNT_W'(idx3_ff) < ERS_CNT_W'(STAMP_DEPTH)))
      else $error("store index out of range");

   // Once a reply has counted, the minimum cannot exceed the maximum
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTAGE] && (recv7_ff != '0)) |-> (min7_ff <= max7_ff))
      else $error("rtt minimum above maximum");

   // The saturating sum never falls below the largest single RTT
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTAGE] |-> (sum7_ff >= ERS_SUM_W'(max7_ff)))
      else $error("rtt sum below maximum");

   // A word that is not an accepted reply reports neither an RTT nor a payload
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTAGE] && !tag7_ff.acc) |-> ((rtt7_ff == '0) && (tag7_ff.pay == '0)))
      else $error("rtt reported without accepted reply");

endmodule
